// File: design/spi_pkg.sv
// shared types, constants and helpers for the spi master shift engine
// used by spi_front, spi_back and spi_master_shift_engine_top; no dependencies
package spi_pkg;

  localparam int WORD_BITS   = 16;
  localparam int NARROW_BITS = 8;
  localparam int CNT_W       = $clog2(WORD_BITS + 1);
  localparam int IDX_W       = $clog2(WORD_BITS);
  localparam int QDEPTH      = 2;
  localparam int QLVL_W      = $clog2(QDEPTH + 1);
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = 24;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CPOL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CPHA = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LSBF = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIV  = 2'd3;

  // word kinds
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_START = 1'b1;

  localparam logic [CNT_W-1:0] LEN_WIDE   = CNT_W'(WORD_BITS);
  localparam logic [CNT_W-1:0] LEN_NARROW = CNT_W'(NARROW_BITS);

  typedef struct packed {
    logic                 kind;
    logic [WORD_BITS-1:0] tx_data;
    logic                 wide;
    logic                 miso;
  } spi_item_t;

  typedef struct packed {
    logic       cpol;
    logic       cpha;
    logic       lsb_first;
    logic [7:0] divider;
  } spi_cfg_t;

  typedef struct packed {
    logic              q_valid;
    logic [QLVL_W-1:0] q_level;
  } spi_qstat_t;

  // bit position for the current bit of a word
  function automatic logic [IDX_W-1:0] bit_idx(input logic [CNT_W-1:0] bits_left,
                                               input logic             wide,
                                               input logic             lsb);
    logic [CNT_W-1:0] n;
    logic [CNT_W-1:0] idx;
    n = wide ? LEN_WIDE : LEN_NARROW;
    if (bits_left == '0 || bits_left > n) begin
      idx = '0;
    end else if (lsb) begin
      idx = n - bits_left;
    end else begin
      idx = bits_left - CNT_W'(1);
    end
    return idx[IDX_W-1:0];
  endfunction

endpackage

// File: design/spi_master_shift_engine_top.sv
// top level of the spi master shift engine: config registers, front queue, engine
// depends on spi_pkg, spi_front and spi_back
//
//   channel   direction  handshake            payload
//   in_       slave      in_tvalid/in_tready  in_tdata, in_tuser (word kind)
//   out_      master     out_tvalid/out_tready out_tdata (one result per input word)
//   cfg_      write      cfg_we               cfg_addr, cfg_wdata
//
// one word per clock sustained while the output is not stalled; each input word is
// one tick of the bit clock and gives exactly one result word; the word is stored in
// the two-entry input queue and its result is registered in the output register
// the engine state advances once per word, so the word rate paces the shift loop
// a stalled output holds the engine while the queue keeps taking words until full
// reset (rst_n low, synchronous) empties the queue, idles the engine and loads
// the registers with polarity 0, phase 0, msb first, divider 4
module spi_master_shift_engine_top import spi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // tx_data[15:0], wide[16], miso_level[17], zeros[23:18]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // kind[0]
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // sck_level[0], mosi_level[1], busy_res[2], done_res[3], rx_data[19:4], zeros[23:20]
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  spi_cfg_t   cfg_r;
  spi_item_t  q_item;
  spi_qstat_t q_stat;
  logic       q_pop;

  // configuration registers; a write takes effect at once, even mid-transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cpol      <= 1'b0;
      cfg_r.cpha      <= 1'b0;
      cfg_r.lsb_first <= 1'b0;
      cfg_r.divider   <= 8'd4;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_CPOL: cfg_r.cpol      <= cfg_wdata[0];
        CFG_CPHA: cfg_r.cpha      <= cfg_wdata[0];
        CFG_LSBF: cfg_r.lsb_first <= cfg_wdata[0];
        CFG_DIV:  cfg_r.divider   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // front: takes words and queues them
  spi_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .q_stat    (q_stat)
  );

  // back: shift engine with output register
  spi_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_item     (q_item),
    .q_stat     (q_stat),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // queue never overfills
  a_qlevel: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.q_level <= QLVL_W'(QDEPTH))
    else $error("input queue level beyond depth");

  // the engine only takes words that are there
  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_stat.q_valid)
    else $error("pop from empty queue");

  // a finished transfer reports idle in the same word
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3] |-> !out_tdata[2])
    else $error("done reported while busy");

  // the input is only blocked when the queue is full
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> q_stat.q_level == QLVL_W'(QDEPTH))
    else $error("input stalled with room in queue");

endmodule

// File: design/spi_front.sv
// input side: accepts words, splits them into fields and queues them
// depends on spi_pkg
module spi_front import spi_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_DATA_W-1:0] in_tdata,
  input  logic                 in_tuser,
  input  logic                 q_pop,
  output spi_item_t            q_item,
  output spi_qstat_t           q_stat
);

  spi_item_t         mem_r [QDEPTH];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [QLVL_W-1:0] count_r, count_nxt;
  logic              push;
  spi_item_t         item;

  always_comb begin
    item.kind    = in_tuser;
    item.tx_data = in_tdata[WORD_BITS-1:0];
    item.wide    = in_tdata[WORD_BITS];
    item.miso    = in_tdata[WORD_BITS+1];
  end

  assign in_tready = (count_r != QLVL_W'(QDEPTH));
  assign push      = in_tvalid && in_tready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + QLVL_W'(push) - QLVL_W'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item;
    end
  end

  assign q_item         = mem_r[rd_ptr_r];
  assign q_stat.q_valid = (count_r != '0);
  assign q_stat.q_level = count_r;

endmodule

// File: design/spi_back.sv
// shift engine: steps the serial clock and data lines one word at a time
// and holds each result in an output register; depends on spi_pkg
module spi_back import spi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  spi_cfg_t              cfg,
  input  spi_item_t             q_item,
  input  spi_qstat_t            q_stat,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic [WORD_BITS-1:0]  tx_r, tx_nxt;
  logic [WORD_BITS-1:0]  rx_r, rx_nxt;
  logic [CNT_W-1:0]      bits_r, bits_nxt;
  logic [7:0]            wait_r, wait_nxt;
  logic                  step_r, step_nxt;
  logic                  sck_r, sck_nxt;
  logic                  mosi_r, mosi_nxt;
  logic                  active_r, active_nxt;
  logic                  wide_r, wide_nxt;
  logic                  ovalid_r;
  logic [OUT_DATA_W-1:0] odata_r, odata_nxt;
  logic [7:0]            half;
  logic [7:0]            wait_inc;
  logic                  done;
  logic [WORD_BITS-1:0]  rx_out;
  logic [IDX_W-1:0]      idx;
  logic [CNT_W-1:0]      bits_dec;

  assign q_pop = q_stat.q_valid && (!ovalid_r || out_tready);

  always_comb begin
    tx_nxt     = tx_r;
    rx_nxt     = rx_r;
    bits_nxt   = bits_r;
    wait_nxt   = wait_r;
    step_nxt   = step_r;
    sck_nxt    = sck_r;
    mosi_nxt   = mosi_r;
    active_nxt = active_r;
    wide_nxt   = wide_r;
    done       = 1'b0;
    rx_out     = '0;
    half       = {1'b0, cfg.divider[7:1]} + 8'd1;
    wait_inc   = wait_r + 8'd1;
    bits_dec   = (bits_r != '0) ? bits_r - CNT_W'(1) : bits_r;
    idx        = bit_idx(bits_r, wide_r, cfg.lsb_first);
    if (!active_r) begin
      sck_nxt = cfg.cpol;
      if (q_item.kind == KIND_START) begin
        // load word and set up the first bit
        wide_nxt   = q_item.wide;
        tx_nxt     = q_item.wide ? q_item.tx_data
                                 : {{(WORD_BITS-NARROW_BITS){1'b0}},
                                    q_item.tx_data[NARROW_BITS-1:0]};
        rx_nxt     = '0;
        bits_nxt   = q_item.wide ? LEN_WIDE : LEN_NARROW;
        active_nxt = 1'b1;
        sck_nxt    = cfg.cpol ^ cfg.cpha;
        mosi_nxt   = tx_nxt[bit_idx(bits_nxt, wide_nxt, cfg.lsb_first)];
        step_nxt   = 1'b0;
        wait_nxt   = '0;
      end
    end else begin
      wait_nxt = wait_inc;
      if (wait_inc >= half) begin
        wait_nxt = '0;
        if (!step_r) begin
          // leading half ends: edge and sample
          sck_nxt     = ~sck_r;
          rx_nxt[idx] = rx_r[idx] | q_item.miso;
          step_nxt    = 1'b1;
        end else begin
          if (!cfg.cpha) begin
            sck_nxt = ~sck_r;
          end
          bits_nxt = bits_dec;
          if (bits_dec == '0) begin
            active_nxt = 1'b0;
            done       = 1'b1;
            rx_out     = rx_r;
            sck_nxt    = cfg.cpol;
            step_nxt   = 1'b0;
          end else begin
            if (cfg.cpha) begin
              sck_nxt = ~sck_r;
            end
            mosi_nxt = tx_r[bit_idx(bits_dec, wide_r, cfg.lsb_first)];
            step_nxt = 1'b0;
          end
        end
      end
    end
    odata_nxt = {4'b0000, rx_out, done, active_nxt,
                 mosi_nxt, (active_nxt ? sck_nxt : cfg.cpol)};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_r     <= '0;
      rx_r     <= '0;
      bits_r   <= '0;
      wait_r   <= '0;
      step_r   <= 1'b0;
      sck_r    <= 1'b0;
      mosi_r   <= 1'b0;
      active_r <= 1'b0;
      wide_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        tx_r     <= tx_nxt;
        rx_r     <= rx_nxt;
        bits_r   <= bits_nxt;
        wait_r   <= wait_nxt;
        step_r   <= step_nxt;
        sck_r    <= sck_nxt;
        mosi_r   <= mosi_nxt;
        active_r <= active_nxt;
        wide_r   <= wide_nxt;
      end
      if (q_pop) begin
        ovalid_r <= 1'b1;
      end else if (out_tready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      odata_r <= odata_nxt;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;

endmodule

// File: tb/sv/tb.sv
// self-checking testbench for spi_master_shift_engine_top: directed table, then random words
// depends on spi_pkg and the design under design/; predicts every result word cycle-free
// and compares it field by field in arrival order
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import spi_pkg::*;

  // levels seen on the lines after one tick word
  typedef struct packed {
    logic        sck;
    logic        mosi;
    logic        busy;
    logic        done;
    logic [15:0] rx;
  } line_levels_t;

  // one row of the directed table: either a register write or a word
  typedef struct packed {
    logic                  reg_row;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    logic                  kind;
    logic [15:0]           tx;
    logic                  wide;
    logic                  miso;
    logic                  typed;   // levels below are the expected result
    line_levels_t          levels;
  } dir_row_t;

  localparam int DIR_ROWS        = 24;
  localparam int PHASES          = 8;
  localparam int WORDS_PER_PHASE = 225;
  localparam int IDLE_PCT        = 51;
  localparam int BOTH_IDLE_PCT   = 27;
  localparam int HOLD_CYCLES     = 80;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = KIND_TICK;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  spi_master_shift_engine_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit, far above the slowest legal run
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // shift engine prediction: own copy of the registers and the engine state
  // ---------------------------------------------------------------------------
  logic        reg_cpol  = 1'b0;
  logic        reg_cpha  = 1'b0;
  logic        reg_lsb   = 1'b0;
  logic [7:0]  reg_div   = 8'd4;

  logic [15:0] sh_tx     = '0;
  logic [15:0] sh_rx     = '0;
  logic [4:0]  sh_left   = '0;
  logic [7:0]  sh_wait   = '0;
  logic        sh_second = 1'b0;   // second half of the current bit
  logic        sh_sck    = 1'b0;
  logic        sh_mosi   = 1'b0;
  logic        sh_busy   = 1'b0;
  logic        sh_wide   = 1'b0;

  line_levels_t levels_q[$];       // predicted result words, oldest first
  int           bad_count = 0;

  // position in the word of the bit now on the line
  function automatic logic [3:0] shift_pos();
    logic [4:0] n;
    n = sh_wide ? 5'd16 : 5'd8;
    if (sh_left == 5'd0 || sh_left > n) return 4'd0;
    return reg_lsb ? 4'(n - sh_left) : 4'(sh_left - 5'd1);
  endfunction

  // set up the next bit; phase 1 makes the leading edge here
  function automatic void load_bit();
    if (reg_cpha) sh_sck = ~sh_sck;
    sh_mosi   = sh_tx[shift_pos()];
    sh_second = 1'b0;
    sh_wait   = '0;
  endfunction

  function automatic line_levels_t step_shift_engine(input logic k, input logic [15:0] d,
                                                     input logic w, input logic m);
    line_levels_t r;
    logic [7:0]   half_len;
    logic [3:0]   pos;
    r = '0;
    if (!sh_busy) begin
      sh_sck = reg_cpol;
      if (k == KIND_START) begin
        sh_wide = w;
        sh_tx   = w ? d : {8'h00, d[7:0]};
        sh_rx   = '0;
        sh_left = w ? 5'd16 : 5'd8;
        sh_busy = 1'b1;
        load_bit();
      end
    end else begin
      // a start while busy is just another tick
      half_len = {1'b0, reg_div[7:1]} + 8'd1;
      sh_wait  = sh_wait + 8'd1;
      if (sh_wait >= half_len) begin
        sh_wait = '0;
        if (!sh_second) begin
          pos        = shift_pos();
          sh_sck     = ~sh_sck;
          sh_rx[pos] = sh_rx[pos] | m;
          sh_second  = 1'b1;
        end else begin
          if (!reg_cpha) sh_sck = ~sh_sck;
          if (sh_left != 5'd0) sh_left = sh_left - 5'd1;
          if (sh_left == 5'd0) begin
            sh_busy   = 1'b0;
            r.done    = 1'b1;
            r.rx      = sh_rx;
            sh_sck    = reg_cpol;
            sh_second = 1'b0;
          end else begin
            load_bit();
          end
        end
      end
    end
    r.sck  = sh_busy ? sh_sck : reg_cpol;
    r.mosi = sh_mosi;
    r.busy = sh_busy;
    return r;
  endfunction

  task automatic note_mismatch(input string what);
    bad_count++;
    if (bad_count <= 40) $display("%0t mismatch: %s", $time, what);
  endtask

  // ---------------------------------------------------------------------------
  // result side: stall control and checking
  // ---------------------------------------------------------------------------
  int          recv_stall_pct = 0;
  int unsigned hold_tag       = 0;   // bumped by the stimulus to ask for one long hold-off
  int unsigned hold_seen      = 0;
  int          hold_left      = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_tag != hold_seen) begin
      // long hold-off, counted here so the sender keeps offering words
      hold_seen  <= hold_tag;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    line_levels_t got;
    line_levels_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.sck  = out_tdata[0];
      got.mosi = out_tdata[1];
      got.busy = out_tdata[2];
      got.done = out_tdata[3];
      got.rx   = out_tdata[19:4];
      if (levels_q.size() == 0) begin
        note_mismatch("result word with nothing pending");
      end else begin
        want = levels_q.pop_front();
        if (got.sck !== want.sck)
          note_mismatch($sformatf("sck got %b want %b", got.sck, want.sck));
        if (got.mosi !== want.mosi)
          note_mismatch($sformatf("mosi got %b want %b", got.mosi, want.mosi));
        if (got.busy !== want.busy)
          note_mismatch($sformatf("busy got %b want %b", got.busy, want.busy));
        if (got.done !== want.done)
          note_mismatch($sformatf("done got %b want %b", got.done, want.done));
        if (got.rx !== want.rx)
          note_mismatch($sformatf("rx got %h want %h", got.rx, want.rx));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  int send_idle_pct = 0;

  // offer one word, optionally after a random gap, and predict it once taken
  task automatic push_word(input logic k, input logic [15:0] d, input logic w,
                           input logic m, input logic typed, input line_levels_t fixed);
    int           gap;
    line_levels_t due;
    gap = 0;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) gap++;
    cfg_we <= 1'b0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= k;
    in_tdata  <= IN_DATA_W'({m, w, d});
    do @(posedge clk); while (!in_tready);
    due = step_shift_engine(k, d, w, m);
    levels_q.push_back(typed ? fixed : due);
  endtask

  // stop offering and wait until every pending result word is back
  task automatic settle();
    in_tvalid <= 1'b0;
    cfg_we    <= 1'b0;
    while (levels_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // registers only change with nothing in flight; the engine may still be mid-transfer
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    settle();
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_CPOL: begin
        reg_cpol = val[0];
        if (!sh_busy) sh_sck = reg_cpol;
      end
      CFG_CPHA: reg_cpha = val[0];
      CFG_LSBF: reg_lsb  = val[0];
      CFG_DIV:  reg_div  = val;
      default: ;
    endcase
  endtask

  dir_row_t dir_tab [DIR_ROWS];

  initial begin
    line_levels_t none;
    logic         k;
    int           counted;
    none = '0;

    // directed part: idle levels after reset, polarity change while idle,
    // lsb-first narrow word with full data in phase 1 at the fastest divider,
    // a start while busy, the full shift and the idle levels after it
    dir_tab = '{
      '{0, CFG_CPOL, 0, KIND_TICK,  16'h0000, 0, 0, 1, '{0, 0, 0, 0, 16'h0000}},
      '{1, CFG_CPOL, 1, KIND_TICK,  16'h0000, 0, 0, 0, '0},
      '{0, CFG_CPOL, 0, KIND_TICK,  16'hffff, 1, 1, 1, '{1, 0, 0, 0, 16'h0000}},
      '{1, CFG_DIV,  0, KIND_TICK,  16'h0000, 0, 0, 0, '0},
      '{1, CFG_CPHA, 1, KIND_TICK,  16'h0000, 0, 0, 0, '0},
      '{1, CFG_LSBF, 1, KIND_TICK,  16'h0000, 0, 0, 0, '0},
      '{0, CFG_CPOL, 0, KIND_START, 16'hffff, 0, 0, 1, '{0, 1, 1, 0, 16'h0000}},
      '{0, CFG_CPOL, 0, KIND_START, 16'h0000, 1, 1, 0, '0},
      '{0, CFG_CPOL, 0, KIND_TICK,  16'h0000, 0, 0, 0, '0},
      '{0, CFG_CPOL, 0, KIND_TICK,  16'h0000, 0, 1, 0, '0},
      '{0, CFG_CPOL, 0, KIND_TICK,  16'h0000, 0, 1, 0, '0},
      '{0, CFG_CPOL, 0, KIND_TICK,  16'h0000, 0, 0, 0, '0},
      '{0, CFG_CPOL, 0, KIND_TICK,  16'h0000, 0, 1, 0, '0},
      '{0, CFG_CPOL, 0, KIND_TICK,  16'h0000, 0, 0, 0, '0},
      '{0, CFG_CPOL, 0, KIND_TICK,  16'h0000, 0, 0, 0, '0},
      '{0, CFG_CPOL, 0, KIND_TICK,  16'h0000, 0, 1, 0, '0},
      '{0, CFG_CPOL, 0, KIND_TICK,  16'h0000, 0, 1, 0, '0},
      '{0, CFG_CPOL, 0, KIND_TICK,  16'h0000, 0, 1, 0, '0},
      '{0, CFG_CPOL, 0, KIND_TICK,  16'h0000, 0, 0, 0, '0},
      '{0, CFG_CPOL, 0, KIND_TICK,  16'h0000, 0, 0, 0, '0},
      '{0, CFG_CPOL, 0, KIND_TICK,  16'h0000, 0, 1, 0, '0},
      '{0, CFG_CPOL, 0, KIND_TICK,  16'h0000, 0, 0, 0, '0},
      '{0, CFG_CPOL, 0, KIND_TICK,  16'h0000, 0, 1, 0, '0},
      '{0, CFG_CPOL, 0, KIND_TICK,  16'h0000, 0, 0, 1, '{1, 1, 0, 0, 16'h0000}}
    };

    // hold reset at the start, then never again
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      if (dir_tab[i].reg_row) begin
        write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
      end else begin
        push_word(dir_tab[i].kind, dir_tab[i].tx, dir_tab[i].wide, dir_tab[i].miso,
                  dir_tab[i].typed, dir_tab[i].levels);
      end
    end

    // random phases; a transfer left running at a phase boundary sees its
    // registers change underneath it (the slow divider phase always does)
    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;             recv_stall_pct <= 0;             end
        1: begin send_idle_pct = IDLE_PCT;      recv_stall_pct <= 0;             end
        2: begin send_idle_pct = 0;             recv_stall_pct <= IDLE_PCT;      end
        default: begin
          send_idle_pct  = BOTH_IDLE_PCT;
          recv_stall_pct <= BOTH_IDLE_PCT;
        end
      endcase
      case (p)
        0: begin
          write_reg(CFG_CPOL, 8'd0); write_reg(CFG_CPHA, 8'd0);
          write_reg(CFG_LSBF, 8'd0); write_reg(CFG_DIV, 8'd2);
        end
        1: begin
          write_reg(CFG_CPOL, 8'd1); write_reg(CFG_CPHA, 8'd0);
          write_reg(CFG_LSBF, 8'd1); write_reg(CFG_DIV, 8'd1);
        end
        2: begin
          write_reg(CFG_CPOL, 8'd0); write_reg(CFG_CPHA, 8'd1);
          write_reg(CFG_LSBF, 8'd0); write_reg(CFG_DIV, 8'd255);
        end
        3: begin
          write_reg(CFG_CPOL, 8'd1); write_reg(CFG_CPHA, 8'd1);
          write_reg(CFG_LSBF, 8'd1); write_reg(CFG_DIV, 8'd0);
        end
        default: begin
          write_reg(CFG_CPOL, 8'($urandom_range(1)));
          write_reg(CFG_CPHA, 8'($urandom_range(1)));
          write_reg(CFG_LSBF, 8'($urandom_range(1)));
          write_reg(CFG_DIV,  8'($urandom_range(3)));
        end
      endcase

      // back-pressure: the receiver stops while words keep coming
      if (p == 0) hold_tag <= hold_tag + 1;

      counted = 0;
      while (counted < WORDS_PER_PHASE) begin
        // mostly starts when idle, a rare ignored start while shifting
        if (!sh_busy) k = ($urandom_range(3) != 0) ? KIND_START : KIND_TICK;
        else          k = ($urandom_range(24) == 0) ? KIND_START : KIND_TICK;
        // idle ticks change nothing, so they do not count
        if (sh_busy || k == KIND_START) counted++;
        push_word(k, 16'($urandom_range(16'hffff)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 1'b0, none);
      end
    end

    settle();
    repeat (4) @(posedge clk);
    if (levels_q.size() != 0)
      note_mismatch($sformatf("%0d result words never arrived", levels_q.size()));
    if (bad_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: files.f
design/spi_pkg.sv
design/spi_front.sv
design/spi_back.sv
design/spi_master_shift_engine_top.sv
tb/sv/tb.sv
